### rtl/core/mtl_pkg.sv
// Shared types, constants and character-class helpers for the Makefile lexer.
// No dependencies; every other file in rtl/core except mtl_if imports this package.
package mtl_pkg;

  localparam int LINE_WIDTH = 16;
  localparam int LINE_OUT_W = 16;
  localparam int GRP_SLOTS  = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  typedef enum logic [3:0] {
    K_WORD   = 4'd0,
    K_VAR    = 4'd1,
    K_AUTO   = 4'd2,
    K_STR    = 4'd3,
    K_ASSIGN = 4'd4,
    K_COLON  = 4'd5,
    K_TAB    = 4'd6,
    K_ENDL   = 4'd7,
    K_ERR    = 4'd8
  } tok_kind_t;

  typedef enum logic [1:0] {
    E_UNRECOG  = 2'd0,
    E_BAD_VAR  = 2'd1,
    E_NL_STR   = 2'd2,
    E_BAD_ESC  = 2'd3
  } err_kind_t;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_COMMENT, M_BSL, M_COLON, M_DOLLAR, M_VAR, M_VPOST,
    M_STR, M_STR_ESC, M_STR_DOLLAR, M_STR_VAR, M_STR_VPOST
  } mode_t;

  typedef struct packed {
    tok_kind_t kind;
    logic      st;
    logic      en;
    logic      hb;
    logic [7:0] b;
    logic      sv;
    logic      ss;
    logic [1:0] ac;
    err_kind_t ek;
  } res_t;

  // Results of one source byte, at most three, all on one line.
  typedef struct packed {
    res_t [GRP_SLOTS-1:0]  r;
    logic [1:0]            cnt;
    logic [LINE_OUT_W-1:0] line;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic      put;
    res_t      res;
    mode_t     mode;
    logic      seg_clr;
    logic      inc;
    logic      halt;
  } disp_t;

  localparam logic [7:0] CH_SP = 8'h20, CH_TAB = 8'h09, CH_NL = 8'h0a, CH_CR = 8'h0d;
  localparam logic [7:0] CH_HASH = 8'h23, CH_BSL = 8'h5c, CH_DOL = 8'h24;
  localparam logic [7:0] CH_DQ = 8'h22, CH_SQ = 8'h27, CH_EQ = 8'h3d, CH_COL = 8'h3a;
  localparam logic [7:0] CH_LP = 8'h28, CH_RP = 8'h29, CH_AT = 8'h40;
  localparam logic [7:0] CH_LT = 8'h3c, CH_CARET = 8'h5e;

  function automatic logic is_word(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5f || c == 8'h2e || c == 8'h25 ||
           c == 8'h2f || c == 8'h2d || c == 8'h2c || c == CH_AT || c == CH_SQ;
  endfunction

  // Bit 2 flags a match; low bits carry the auto variable code.
  function automatic logic [2:0] auto_of(logic [7:0] c);
    logic [2:0] a;
    a = 3'b000;
    if (c == CH_AT)    a = 3'b100;
    if (c == CH_LT)    a = 3'b101;
    if (c == CH_CARET) a = 3'b110;
    return a;
  endfunction

  // Bit 8 flags a known escape; low bits carry the decoded byte.
  function automatic logic [8:0] unescape(logic [7:0] c);
    logic [8:0] u;
    u = '0;
    case (c)
      CH_DQ, CH_SQ, CH_BSL, CH_HASH: u = {1'b1, c};
      8'h6e:                         u = {1'b1, CH_NL};
      8'h72:                         u = {1'b1, CH_CR};
      8'h74:                         u = {1'b1, CH_TAB};
      default:                       u = '0;
    endcase
    return u;
  endfunction

  function automatic res_t mk(tok_kind_t k, logic st, logic en, logic hb, logic [7:0] b,
                              logic sv, logic ss, logic [1:0] ac, err_kind_t ek);
    res_t r;
    r.kind = k;
    r.st   = st;
    r.en   = en;
    r.hb   = hb;
    r.b    = hb ? b : 8'h00;
    r.sv   = sv;
    r.ss   = ss;
    r.ac   = ac;
    r.ek   = ek;
    return r;
  endfunction

  // Action for the first byte of a new token.
  function automatic disp_t dispatch(logic [7:0] c);
    disp_t d;
    d.put     = 1'b0;
    d.res     = mk(K_WORD, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
    d.mode    = M_IDLE;
    d.seg_clr = 1'b0;
    d.inc     = 1'b0;
    d.halt    = 1'b0;
    if (c == CH_SP) begin
      d.mode = M_IDLE;
    end else if (c == CH_HASH) begin
      d.mode = M_COMMENT;
    end else if (c == CH_BSL) begin
      d.mode = M_BSL;
    end else if (is_word(c)) begin
      d.put  = 1'b1;
      d.res  = mk(K_WORD, 1'b1, 1'b0, 1'b1, c, 1'b0, 1'b0, 2'd0, E_UNRECOG);
      d.mode = M_WORD;
    end else if (c == CH_DOL) begin
      d.mode = M_DOLLAR;
    end else if (c == CH_DQ) begin
      d.put     = 1'b1;
      d.res     = mk(K_STR, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
      d.seg_clr = 1'b1;
      d.mode    = M_STR;
    end else if (c == CH_EQ) begin
      d.put = 1'b1;
      d.res = mk(K_ASSIGN, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
    end else if (c == CH_COL) begin
      d.mode = M_COLON;
    end else if (c == CH_TAB) begin
      d.put = 1'b1;
      d.res = mk(K_TAB, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
    end else if (c == CH_NL) begin
      d.put = 1'b1;
      d.res = mk(K_ENDL, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
      d.inc = 1'b1;
    end else begin
      d.put  = 1'b1;
      d.res  = mk(K_ERR, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
      d.halt = 1'b1;
    end
    return d;
  endfunction

endpackage

### rtl/core/mtl_if.sv
// Valid/ready channel interfaces for the lexer: source bytes in, token events out.
// Plain logic payloads; no package dependency.
interface mtl_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_source;

  modport source (output valid, in_byte, end_of_source, input ready);
  modport sink   (input valid, in_byte, end_of_source, output ready);
endinterface

interface mtl_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic        starts_token;
  logic        ends_token;
  logic        has_byte;
  logic [7:0]  char_byte;
  logic        segment_is_var;
  logic        segment_start;
  logic [1:0]  auto_code;
  logic [15:0] line_number;
  logic [1:0]  error_kind;
  logic        last;

  modport source (output valid, token_kind, starts_token, ends_token, has_byte, char_byte,
                  segment_is_var, segment_start, auto_code, line_number, error_kind, last,
                  input ready);
  modport sink   (input valid, token_kind, starts_token, ends_token, has_byte, char_byte,
                  segment_is_var, segment_start, auto_code, line_number, error_kind, last,
                  output ready);
endinterface

### rtl/core/mtl_front.sv
// Front end: accepts source bytes, runs the lexer state machine, packs results.
// Depends on mtl_pkg and mtl_src_if.
module mtl_front (
  input  logic            clk,
  input  logic            rst,
  mtl_src_if.sink         src,
  input  mtl_pkg::q_stat_t qs,
  output logic            push,
  output mtl_pkg::grp_t   push_grp
);
  import mtl_pkg::*;

  mode_t                 mode, mode_next;
  logic [LINE_WIDTH-1:0] line_count, line_count_next;
  logic                  halted, halted_next;
  logic                  seg_open, seg_open_next;
  logic                  name_seen, name_seen_next;

  res_t [GRP_SLOTS-1:0]  r;
  logic [1:0]            n;
  logic                  acc, fin, err, do_disp, in_str, inc;
  err_kind_t             ek;
  disp_t                 d;
  logic [7:0]            c;
  logic [2:0]            au;
  logic [8:0]            ue;
  tok_kind_t             kk;
  logic [31:0]           line_wide;

  assign src.ready = !qs.full;
  assign acc       = src.valid && src.ready;
  assign c         = src.in_byte;
  assign fin       = src.end_of_source;
  assign au        = auto_of(c);
  assign ue        = unescape(c);
  assign d         = dispatch(c);
  assign line_wide = 32'(line_count);

  always_comb begin
    r              = '0;
    n              = 2'd0;
    mode_next      = mode;
    halted_next    = halted;
    seg_open_next  = seg_open;
    name_seen_next = name_seen;
    inc            = 1'b0;
    err            = 1'b0;
    ek             = E_UNRECOG;
    do_disp        = 1'b0;
    in_str         = (mode == M_STR_VAR) || (mode == M_STR_VPOST);
    kk             = in_str ? K_STR : K_VAR;
    if (!halted) begin
      unique case (mode)
        M_IDLE: do_disp = 1'b1;
        M_WORD: begin
          if (is_word(c)) begin
            r[n] = mk(K_WORD, 1'b0, 1'b0, 1'b1, c, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end else begin
            r[n] = mk(K_WORD, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
            do_disp = 1'b1;
          end
        end
        M_COMMENT: if (c == CH_NL) do_disp = 1'b1;
        M_BSL: begin
          if (c == CH_NL) begin
            inc       = 1'b1;
            mode_next = M_IDLE;
          end else begin
            err = 1'b1;
            ek  = E_UNRECOG;
          end
        end
        M_COLON: begin
          if (c == CH_EQ) begin
            r[n] = mk(K_ASSIGN, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            r[n] = mk(K_COLON, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
            do_disp = 1'b1;
          end
        end
        M_DOLLAR: begin
          mode_next = M_IDLE;
          if (c == CH_LP) begin
            name_seen_next = 1'b0;
            mode_next      = M_VAR;
          end else if (au[2]) begin
            r[n] = mk(K_AUTO, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, au[1:0], E_UNRECOG);
            n = n + 2'd1;
          end else if (is_word(c)) begin
            r[n] = mk(K_VAR, 1'b1, 1'b1, 1'b1, c, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end else if (c == CH_SP) begin
            r[n] = mk(K_WORD, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end else if (c == CH_DOL || c == CH_NL) begin
            r[n] = mk(K_WORD, 1'b1, 1'b1, 1'b1, CH_DOL, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end else begin
            err = 1'b1;
            ek  = E_BAD_VAR;
          end
        end
        M_VAR, M_STR_VAR, M_VPOST, M_STR_VPOST: begin
          if ((mode == M_VAR || mode == M_STR_VAR) && !name_seen) begin
            if (c == CH_SP) begin
              mode_next = mode;
            end else if (!is_word(c)) begin
              err = 1'b1;
              ek  = E_BAD_VAR;
            end else begin
              r[n] = mk(kk, !in_str, 1'b0, 1'b1, c, in_str, in_str, 2'd0, E_UNRECOG);
              n = n + 2'd1;
              name_seen_next = 1'b1;
            end
          end else if ((mode == M_VAR || mode == M_STR_VAR) && is_word(c)) begin
            r[n] = mk(kk, 1'b0, 1'b0, 1'b1, c, in_str, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end else if (c == CH_SP) begin
            mode_next = in_str ? M_STR_VPOST : M_VPOST;
          end else if (c != CH_RP) begin
            err = 1'b1;
            ek  = E_BAD_VAR;
          end else if (in_str) begin
            seg_open_next = 1'b0;
            mode_next     = M_STR;
          end else begin
            r[n] = mk(K_VAR, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_STR: begin
          if (c == CH_NL) begin
            err = 1'b1;
            ek  = E_NL_STR;
          end else if (c == CH_DQ) begin
            r[n] = mk(K_STR, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (c == CH_DOL) begin
            mode_next = M_STR_DOLLAR;
          end else if (c == CH_BSL) begin
            mode_next = M_STR_ESC;
          end else begin
            r[n] = mk(K_STR, 1'b0, 1'b0, 1'b1, c, 1'b0, !seg_open, 2'd0, E_UNRECOG);
            n = n + 2'd1;
            seg_open_next = 1'b1;
          end
        end
        M_STR_ESC: begin
          if (!ue[8]) begin
            err = 1'b1;
            ek  = E_BAD_ESC;
          end else begin
            r[n] = mk(K_STR, 1'b0, 1'b0, 1'b1, ue[7:0], 1'b0, !seg_open, 2'd0, E_UNRECOG);
            n = n + 2'd1;
            seg_open_next = 1'b1;
            mode_next     = M_STR;
          end
        end
        M_STR_DOLLAR: begin
          if (c == CH_LP) begin
            name_seen_next = 1'b0;
            mode_next      = M_STR_VAR;
          end else if (au[2]) begin
            r[n] = mk(K_STR, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, au[1:0], E_UNRECOG);
            n = n + 2'd1;
            seg_open_next = 1'b0;
            mode_next     = M_STR;
          end else if (is_word(c)) begin
            r[n] = mk(K_STR, 1'b0, 1'b0, 1'b1, c, 1'b1, 1'b1, 2'd0, E_UNRECOG);
            n = n + 2'd1;
            seg_open_next = 1'b0;
            mode_next     = M_STR;
          end else begin
            err = 1'b1;
            ek  = E_BAD_VAR;
          end
        end
        default: begin
          err = 1'b1;
          ek  = E_UNRECOG;
        end
      endcase

      // A new token starts with this byte.
      if (do_disp) begin
        mode_next = d.mode;
        if (d.put) begin
          r[n] = d.res;
          n = n + 2'd1;
        end
        if (d.seg_clr) seg_open_next = 1'b0;
        if (d.inc)     inc = 1'b1;
        if (d.halt)    halted_next = 1'b1;
      end

      if (err) begin
        r[n] = mk(K_ERR, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, ek);
        n = n + 2'd1;
        halted_next = 1'b1;
        mode_next   = M_IDLE;
      end

      // Close whatever is still open at the end of the source.
      if (fin && !halted_next) begin
        case (mode_next)
          M_WORD: begin
            r[n] = mk(K_WORD, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end
          M_BSL: begin
            r[n] = mk(K_ERR, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end
          M_COLON: begin
            r[n] = mk(K_COLON, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end
          M_DOLLAR: begin
            r[n] = mk(K_WORD, 1'b1, 1'b1, 1'b1, CH_DOL, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end
          M_VAR, M_VPOST, M_STR_DOLLAR, M_STR_VAR, M_STR_VPOST: begin
            r[n] = mk(K_ERR, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_BAD_VAR);
            n = n + 2'd1;
          end
          M_STR: begin
            r[n] = mk(K_STR, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_UNRECOG);
            n = n + 2'd1;
          end
          M_STR_ESC: begin
            r[n] = mk(K_ERR, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, E_BAD_ESC);
            n = n + 2'd1;
          end
          default: ;
        endcase
      end
    end

    line_count_next = line_count;
    if (inc && (line_count != '1)) line_count_next = line_count + LINE_WIDTH'(1);

    push          = acc && (n != 2'd0);
    push_grp.r    = r;
    push_grp.cnt  = n;
    push_grp.line = line_wide[LINE_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && fin)) begin
      mode       <= M_IDLE;
      line_count <= LINE_WIDTH'(1);
      halted     <= 1'b0;
      seg_open   <= 1'b0;
      name_seen  <= 1'b0;
    end else if (acc) begin
      mode       <= mode_next;
      line_count <= line_count_next;
      halted     <= halted_next;
      seg_open   <= seg_open_next;
      name_seen  <= name_seen_next;
    end
  end

endmodule

### rtl/core/mtl_queue.sv
// Short queue of result groups between the front end and the output stage.
// Depends on mtl_pkg.
module mtl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mtl_pkg::grp_t    push_grp,
  input  logic             pop,
  output mtl_pkg::grp_t    head,
  output mtl_pkg::q_stat_t qs
);
  import mtl_pkg::*;

  grp_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign head     = mem[rd_ptr];
  assign qs.full  = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign qs.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      if (push && !pop)      count <= count + (Q_PTR_W+1)'(1);
      else if (pop && !push) count <= count - (Q_PTR_W+1)'(1);
    end
  end

endmodule

### rtl/core/mtl_back.sv
// Output stage: walks the results of the head group, one per cycle unless tok stalls, into a register.
// Depends on mtl_pkg and mtl_tok_if.
module mtl_back (
  input  logic             clk,
  input  logic             rst,
  input  mtl_pkg::grp_t    head,
  input  mtl_pkg::q_stat_t qs,
  output logic             pop,
  mtl_tok_if.source        tok
);
  import mtl_pkg::*;

  logic [1:0] idx;
  logic       load, is_last;
  res_t       cur;

  assign load    = !tok.valid || tok.ready;
  assign cur     = head.r[idx];
  assign is_last = (idx == head.cnt - 2'd1);
  assign pop     = load && !qs.empty && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      tok.valid <= !qs.empty;
      if (!qs.empty) idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !qs.empty) begin
      tok.token_kind     <= cur.kind;
      tok.starts_token   <= cur.st;
      tok.ends_token     <= cur.en;
      tok.has_byte       <= cur.hb;
      tok.char_byte      <= cur.b;
      tok.segment_is_var <= cur.sv;
      tok.segment_start  <= cur.ss;
      tok.auto_code      <= cur.ac;
      tok.line_number    <= head.line;
      tok.error_kind     <= cur.ek;
      tok.last           <= is_last;
    end
  end

endmodule

### rtl/core/makefile_token_lexer.sv
// Top level of the Makefile token lexer: front end, result queue, output stage.
// Depends on mtl_pkg, mtl_if, mtl_front, mtl_queue and mtl_back.
//
// Usage:
//   src carries one source byte per transaction (in_byte, end_of_source).
//   tok carries token events; a byte causes zero to three events, the last
//   one flagged with last. Bytes that cause nothing (spaces, comment text,
//   held characters after ':', '$' or a backslash) produce no transaction.
//   end_of_source flushes pending tokens and returns the lexer to its
//   starting state, line one, for the next source.
// Path: the first event of a byte is written into the queue by the front end
//   and then loaded into the output register before it leaves tok.
// Throughput: src takes one byte per cycle unless the queue is full; tok
//   gives one event per cycle unless tok.ready is low. The four-group queue
//   absorbs fan-out bytes; the single output register sets the event rate.
// Reset (rst, synchronous): empty the queue, drop the output, line count one.
// Stall: when tok.ready is low the output register holds its event; the queue
//   keeps filling, and src.ready drops only when all four groups are taken.
// After an error event the lexer ignores bytes until end_of_source.
module makefile_token_lexer (
  input logic       clk,
  input logic       rst,
  mtl_src_if.sink   src,
  mtl_tok_if.source tok
);
  import mtl_pkg::*;

  grp_t    push_grp, head;
  q_stat_t qs;
  logic    push, pop;

  // Classify bytes and build one result group per byte that yields results.
  mtl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .src      (src),
    .qs       (qs),
    .push     (push),
    .push_grp (push_grp)
  );

  // Decouple byte intake from event delivery.
  mtl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .qs       (qs)
  );

  // Serialize each group into single events.
  mtl_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .qs   (qs),
    .pop  (pop),
    .tok  (tok)
  );

endmodule

### rtl/core/mtl_checker.sv
// Port-level checks for the lexer output channel, bound to the top level.
// Depends on mtl_pkg and makefile_token_lexer.
module mtl_checker (
  input logic        clk,
  input logic        rst,
  input logic        tok_valid,
  input logic        tok_ready,
  input logic [3:0]  tok_kind,
  input logic        tok_starts,
  input logic        tok_ends,
  input logic        tok_has_byte,
  input logic [7:0]  tok_char_byte,
  input logic [15:0] tok_line
);
  import mtl_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) && $stable(tok_char_byte))
    else $error("stalled event changed");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("event right after reset");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_kind == K_ERR |-> tok_starts && tok_ends && !tok_has_byte)
    else $error("malformed error event");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_has_byte |-> tok_char_byte == 8'h00)
    else $error("stray content byte");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> tok_line != 16'd0)
    else $error("line number zero");

endmodule

bind makefile_token_lexer mtl_checker u_mtl_checker (
  .clk           (clk),
  .rst           (rst),
  .tok_valid     (tok.valid),
  .tok_ready     (tok.ready),
  .tok_kind      (tok.token_kind),
  .tok_starts    (tok.starts_token),
  .tok_ends      (tok.ends_token),
  .tok_has_byte  (tok.has_byte),
  .tok_char_byte (tok.char_byte),
  .tok_line      (tok.line_number)
);
